// File: hdl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_RUN(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define ASSERT_ALL(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/crcpr_pkg.sv
// Types, constants and the byte update function of the pitched-row CRC-32C block.
package crcpr_pkg;

  localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;
  localparam logic [31:0] CRC_SEED = 32'hFFFF_FFFF;

  localparam int WIDTH_BITS = 21;
  localparam int COUNT_BITS = 16;
  localparam int ADDR_BITS  = 4;

  localparam logic [1:0] REG_ROW_WIDTH  = 2'd0;
  localparam logic [1:0] REG_ROW_STRIDE = 2'd1;
  localparam logic [1:0] REG_ROW_COUNT  = 2'd2;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_DATA  = 2'd1;
  localparam logic [1:0] OP_LAST  = 2'd2;
  localparam logic [1:0] OP_EMPTY = 2'd3;

  typedef struct packed {
    logic [WIDTH_BITS-1:0] row_width_bytes;
    logic [WIDTH_BITS-1:0] row_stride_bytes;
    logic [COUNT_BITS-1:0] row_count;
  } cfg_t;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data;
  } cmd_t;

  function automatic logic [31:0] crc_byte(logic [31:0] crc, logic [7:0] b);
    logic [31:0] r;
    r = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? (CRC_POLY ^ (r >> 1)) : (r >> 1);
    end
    return r;
  endfunction

endpackage

// File: hdl/crcpr_fifo.sv
// Small register FIFO used between the front, the back and the result ports.
module crcpr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == (AW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + (AW+1)'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - (AW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

// File: hdl/crcpr_front.sv
// Front end: tracks row and column, drops padding and classifies each transaction.
module crcpr_front (
  input  logic          clk,
  input  logic          rst,
  input  crcpr_pkg::cfg_t cfg,
  input  logic          accept,
  input  logic          action,
  input  logic [7:0]    data_byte,
  output logic          cmd_valid,
  output crcpr_pkg::cmd_t cmd
);
  import crcpr_pkg::*;

  logic [WIDTH_BITS-1:0] column;
  logic [WIDTH_BITS-1:0] column_next;
  logic [COUNT_BITS-1:0] row;
  logic [COUNT_BITS-1:0] row_next;
  logic                  finished;
  logic                  finished_next;
  logic [WIDTH_BITS-1:0] pitch;
  logic [WIDTH_BITS-1:0] col_inc;
  logic                  no_image;
  logic                  wrap_check;

  assign pitch    = (cfg.row_stride_bytes > cfg.row_width_bytes) ?
                    cfg.row_stride_bytes : cfg.row_width_bytes;
  assign col_inc  = column + WIDTH_BITS'(1);
  assign no_image = (cfg.row_width_bytes == '0) || (cfg.row_count == '0);

  always_comb begin
    column_next   = column;
    row_next      = row;
    finished_next = finished;
    cmd_valid     = 1'b0;
    cmd.op        = OP_DATA;
    cmd.data      = data_byte;
    wrap_check    = 1'b0;
    if (accept) begin
      if (action) begin
        column_next   = '0;
        row_next      = '0;
        finished_next = no_image;
        cmd_valid     = 1'b1;
        cmd.op        = no_image ? OP_EMPTY : OP_START;
      end else if (!finished && !no_image) begin
        column_next = col_inc;
        wrap_check  = 1'b1;
        if (column < cfg.row_width_bytes) begin
          cmd_valid = 1'b1;
          if ((col_inc == cfg.row_width_bytes) &&
              ({1'b0, row} + (COUNT_BITS+1)'(1) >= {1'b0, cfg.row_count})) begin
            finished_next = 1'b1;
            cmd.op        = OP_LAST;
            wrap_check    = 1'b0;
          end
        end
        if (wrap_check && (col_inc >= pitch)) begin
          column_next = '0;
          row_next    = row + COUNT_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column   <= '0;
      row      <= '0;
      finished <= 1'b0;
    end else begin
      column   <= column_next;
      row      <= row_next;
      finished <= finished_next;
    end
  end

endmodule

// File: hdl/crcpr_back.sv
// Back end: runs the CRC-32C byte update and produces the final hash.
module crcpr_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_empty,
  input  crcpr_pkg::cmd_t cmd,
  output logic          cmd_pop,
  input  logic          res_full,
  output logic          res_push,
  output logic [31:0]   res_hash
);
  import crcpr_pkg::*;

  logic [31:0] crc;
  logic [31:0] crc_next;
  logic [31:0] crc_upd;

  assign cmd_pop = !cmd_empty && !res_full;
  assign crc_upd = crc_byte(crc, cmd.data);

  always_comb begin
    crc_next = crc;
    res_push = 1'b0;
    res_hash = '0;
    if (cmd_pop) begin
      case (cmd.op)
        OP_START: begin
          crc_next = CRC_SEED;
        end
        OP_DATA: begin
          crc_next = crc_upd;
        end
        OP_LAST: begin
          crc_next = crc_upd;
          res_push = 1'b1;
          res_hash = ~crc_upd;
        end
        OP_EMPTY: begin
          crc_next = CRC_SEED;
          res_push = 1'b1;
        end
        default: begin
          crc_next = crc;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc <= CRC_SEED;
    end else begin
      crc <= crc_next;
    end
  end

endmodule

// File: hdl/crc32c_pitched_rows.sv
// Top level of the pitched-row CRC-32C block: register port, front, queues and back.
// Throughput: one transaction per cycle on both sides while neither side stalls.
// Path: the hash of an image reaches the result ports after the last useful byte or an
// empty-image start is accepted; the front writes the command queue, then the back the result queue.
// Reset: synchronous; clears counters, queues and registers, and sets the CRC to all ones.
module crc32c_pitched_rows #(
  parameter int CMD_DEPTH = 2,
  parameter int RES_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        action,
  input  logic [7:0]  data_byte,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] hash,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [crcpr_pkg::ADDR_BITS-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import crcpr_pkg::*;

  cfg_t        cfg;
  logic        accept;
  logic        cmd_valid;
  cmd_t        cmd_in;
  cmd_t        cmd_out;
  logic [$bits(cmd_t)-1:0] cmd_rd;
  logic        cmd_full;
  logic        cmd_empty;
  logic        cmd_pop;
  logic        res_full;
  logic        res_push;
  logic [31:0] res_hash;

  assign pready = 1'b1;
  assign accept = push && !full;
  assign full   = cmd_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        REG_ROW_WIDTH:  cfg.row_width_bytes  <= pwdata[WIDTH_BITS-1:0];
        REG_ROW_STRIDE: cfg.row_stride_bytes <= pwdata[WIDTH_BITS-1:0];
        REG_ROW_COUNT:  cfg.row_count        <= pwdata[COUNT_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_ROW_WIDTH:  prdata = {{(32-WIDTH_BITS){1'b0}}, cfg.row_width_bytes};
      REG_ROW_STRIDE: prdata = {{(32-WIDTH_BITS){1'b0}}, cfg.row_stride_bytes};
      REG_ROW_COUNT:  prdata = {{(32-COUNT_BITS){1'b0}}, cfg.row_count};
      default:        prdata = '0;
    endcase
  end

  crcpr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .accept    (accept),
    .action    (action),
    .data_byte (data_byte),
    .cmd_valid (cmd_valid),
    .cmd       (cmd_in)
  );

  crcpr_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_valid),
    .wr_data (cmd_in),
    .full    (cmd_full),
    .rd_en   (cmd_pop),
    .rd_data (cmd_rd),
    .empty   (cmd_empty)
  );

  assign cmd_out = cmd_t'(cmd_rd);

  crcpr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_hash  (res_hash)
  );

  crcpr_fifo #(
    .WIDTH (32),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push),
    .wr_data (res_hash),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (hash),
    .empty   (empty)
  );

endmodule

// File: hdl/crcpr_check.sv
// Port-level checker for the pitched-row CRC-32C block, bound to the top level.
`include "assert_macros.svh"

module crcpr_check (
  input logic        clk,
  input logic        rst,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [31:0] hash,
  input logic        psel,
  input logic        pwrite,
  input logic [31:0] prdata
);

  `ASSERT_ALL(a_reset_empty, clk, rst |=> empty, "result queue not empty after reset")
  `ASSERT_ALL(a_reset_room, clk, rst |=> !full, "input side full after reset")
  `ASSERT_RUN(a_result_holds, clk, rst, (!empty && !pop) |=> (!empty && $stable(hash)), "waiting result changed before pop")
  `ASSERT_RUN(a_read_width, clk, rst, (psel && !pwrite) |-> (prdata[31:21] == 11'd0), "register read wider than its field")

endmodule

bind crc32c_pitched_rows crcpr_check u_check (.*);

// File: verif/tb_top.sv
// Self-checking testbench for the pitched-row CRC-32C block: directed cases, then random images.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import crcpr_pkg::*;

  localparam bit ACT_DATA  = 1'b0;
  localparam bit ACT_START = 1'b1;

  localparam int WIDTH_MAX    = 1048576;
  localparam int COUNT_MAX    = 65535;
  localparam int MAX_GAP      = 40;
  localparam int DRAIN_CYCLES = 8;
  localparam int REPORT_LIMIT = 10;
  localparam int PHASE_ITEMS  = 360;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 push      = 1'b0;
  logic                 action    = ACT_DATA;
  logic [7:0]           data_byte = 8'h00;
  logic                 pop       = 1'b0;
  logic                 psel      = 1'b0;
  logic                 penable   = 1'b0;
  logic                 pwrite    = 1'b0;
  logic [ADDR_BITS-1:0] paddr     = '0;
  logic [31:0]          pwdata    = '0;
  logic                 full;
  logic                 empty;
  logic                 pready;
  logic [31:0]          hash;
  logic [31:0]          prdata;

  crc32c_pitched_rows DUT (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .action   (action),
    .data_byte(data_byte),
    .empty    (empty),
    .pop      (pop),
    .hash     (hash),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  // Image geometry as last written, and the running checksum state.
  logic [WIDTH_BITS-1:0] cfg_width  = '0;
  logic [WIDTH_BITS-1:0] cfg_stride = '0;
  logic [COUNT_BITS-1:0] cfg_rows   = '0;
  logic [31:0]           crc_acc    = CRC_SEED;
  logic [WIDTH_BITS-1:0] col_pos    = '0;
  logic [COUNT_BITS-1:0] row_pos    = '0;
  bit                    img_done   = 1'b0;

  logic [31:0] hash_expect_q[$];

  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  int items_taken        = 0;
  int images_started     = 0;
  int hashes_checked     = 0;
  int mismatches         = 0;

  function automatic logic [31:0] crc32c_advance(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    int k;
    r = c ^ {24'd0, b};
    for (k = 0; k < 8; k++) begin
      r = (r >> 1) ^ (r[0] ? CRC_POLY : 32'd0);
    end
    return r;
  endfunction

  task automatic predict_hash(input bit act, input logic [7:0] b, output bit taken);
    logic [WIDTH_BITS-1:0] pitch;
    taken = 1'b0;
    if (act == ACT_START) begin
      taken    = 1'b1;
      crc_acc  = CRC_SEED;
      col_pos  = '0;
      row_pos  = '0;
      img_done = 1'b0;
      if (cfg_width == '0 || cfg_rows == '0) begin
        img_done = 1'b1;
        hash_expect_q.push_back(32'd0);
      end
      return;
    end
    if (img_done || cfg_width == '0 || cfg_rows == '0) return;
    taken = 1'b1;
    pitch = (cfg_stride > cfg_width) ? cfg_stride : cfg_width;
    if (col_pos < cfg_width) begin
      crc_acc = crc32c_advance(crc_acc, b);
      col_pos = col_pos + WIDTH_BITS'(1);
      if (col_pos == cfg_width && ({1'b0, row_pos} + 17'd1) >= {1'b0, cfg_rows}) begin
        img_done = 1'b1;
        hash_expect_q.push_back(~crc_acc);
        return;
      end
    end else begin
      col_pos = col_pos + WIDTH_BITS'(1);
    end
    if (col_pos >= pitch) begin
      col_pos = '0;
      row_pos = row_pos + COUNT_BITS'(1);
    end
  endtask

  // Result side: compare each popped hash, then pick the next pop at random.
  always @(posedge clk) begin : hash_check
    logic [31:0] want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (hash_expect_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("unexpected hash: expected none, got %h", hash);
        end else begin
          want = hash_expect_q.pop_front();
          hashes_checked++;
          if (hash !== want) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display("hash mismatch: expected %h, got %h", want, hash);
          end
        end
      end
      pop <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Drop push and wait for every pending hash plus the pipeline latency.
  task automatic settle();
    push <= 1'b0;
    while (hash_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_ROW_WIDTH:  cfg_width  = val[WIDTH_BITS-1:0];
      REG_ROW_STRIDE: cfg_stride = val[WIDTH_BITS-1:0];
      REG_ROW_COUNT:  cfg_rows   = val[COUNT_BITS-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_geometry(input int w, input int s, input int n);
    settle();
    write_reg(REG_ROW_WIDTH, w);
    write_reg(REG_ROW_STRIDE, s);
    write_reg(REG_ROW_COUNT, n);
  endtask

  task automatic send_item(input bit act, input logic [7:0] b);
    int gap;
    bit taken;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct) gap++;
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push      <= 1'b1;
    action    <= act;
    data_byte <= b;
    do @(posedge clk); while (full);
    predict_hash(act, b, taken);
    if (taken) items_taken++;
    if (act == ACT_START) images_started++;
  endtask

  task automatic test_data_before_start();
    send_item(ACT_DATA, 8'h00);
    send_item(ACT_DATA, 8'hFF);
    set_geometry(2, 0, 1);
    send_item(ACT_DATA, 8'hA5);
    send_item(ACT_DATA, 8'h5A);
    send_item(ACT_DATA, 8'h3C);
  endtask

  task automatic test_empty_images();
    set_geometry(0, 5, 3);
    send_item(ACT_START, 8'hFF);
    set_geometry(4, 0, 0);
    send_item(ACT_START, 8'h00);
    send_item(ACT_DATA, 8'h81);
    set_geometry(WIDTH_MAX, WIDTH_MAX, 0);
    send_item(ACT_START, 8'h7E);
  endtask

  task automatic test_narrow_stride();
    set_geometry(2, 1, 2);
    send_item(ACT_START, 8'h00);
    send_item(ACT_DATA, 8'h00);
    send_item(ACT_DATA, 8'hFF);
    send_item(ACT_DATA, 8'h01);
    send_item(ACT_DATA, 8'h80);
  endtask

  task automatic test_padded_rows();
    set_geometry(1, 3, 2);
    send_item(ACT_START, 8'h00);
    send_item(ACT_DATA, 8'hC3);
    send_item(ACT_DATA, 8'hFF);
    send_item(ACT_DATA, 8'hFF);
    send_item(ACT_DATA, 8'h3C);
  endtask

  // Shrink the geometry under a started image: the column wraps, then the row ends it.
  task automatic test_midimage_change();
    set_geometry(WIDTH_MAX, WIDTH_MAX, COUNT_MAX);
    send_item(ACT_START, 8'h55);
    repeat (5) send_item(ACT_DATA, 8'($urandom_range(255)));
    set_geometry(4, 0, 1);
    repeat (5) send_item(ACT_DATA, 8'($urandom_range(255)));
  endtask

  task automatic run_random_images(input int idle_pct, input int stall_pct, input int quota);
    int w;
    int s;
    int n;
    int pick;
    int stop_at;
    longint pitch;
    longint nbytes;
    bit fresh;
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    stop_at = items_taken + quota;
    fresh   = 1'b1;
    while (items_taken < stop_at) begin
      if (fresh || $urandom_range(1) == 1) begin
        pick = $urandom_range(99);
        if (pick < 6) begin
          w = ($urandom_range(1) == 1) ? 0 : $urandom_range(1, 8);
          n = (w == 0) ? $urandom_range(0, 4) : 0;
          s = $urandom_range(0, 12);
        end else if (pick < 12) begin
          w = $urandom_range(1, WIDTH_MAX);
          s = $urandom_range(0, WIDTH_MAX);
          n = $urandom_range(1, COUNT_MAX);
        end else begin
          w = $urandom_range(1, 8);
          s = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
          n = $urandom_range(1, 4);
        end
        set_geometry(w, s, n);
        fresh = 1'b0;
      end
      pitch  = (cfg_stride > cfg_width) ? cfg_stride : cfg_width;
      nbytes = (cfg_width == '0 || cfg_rows == '0) ? 0 : (cfg_rows - 1) * pitch + cfg_width;
      pick   = $urandom_range(99);
      if (pick < 10) begin
        repeat ($urandom_range(1, 10))
          send_item(($urandom_range(9) < 3) ? ACT_START : ACT_DATA, 8'($urandom_range(255)));
      end else begin
        send_item(ACT_START, 8'($urandom_range(255)));
        if (nbytes > 64)
          nbytes = $urandom_range(1, 20);
        else if (pick < 20 && nbytes > 0)
          nbytes = $urandom_range(0, nbytes - 1);
        repeat (nbytes) send_item(ACT_DATA, 8'($urandom_range(255)));
        if ($urandom_range(4) == 0)
          repeat ($urandom_range(1, 3)) send_item(ACT_DATA, 8'($urandom_range(255)));
      end
    end
    settle();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_data_before_start();
    test_empty_images();
    test_narrow_stride();
    test_padded_rows();
    test_midimage_change();
    run_random_images(0, 0, PHASE_ITEMS);
    run_random_images(77, 0, PHASE_ITEMS);
    run_random_images(0, 77, PHASE_ITEMS);
    run_random_images(21, 21, PHASE_ITEMS);
    settle();
    $display("covered %0d images over %0d checksum-path transactions", images_started,
             items_taken);
    $display("compared %0d hashes, %0d mismatches", hashes_checked, mismatches);
    if (mismatches == 0) begin
      $display("crc32c_pitched_rows regression: pass");
    end else begin
      $display("crc32c_pitched_rows regression: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("crc32c_pitched_rows regression: fail");
    $finish;
  end

endmodule
